/* sv/ibb_pkg.sv */
// Shared constants and types for the box binning core.
package ibb_pkg;

    localparam int PIXEL_BITS = 16;
    localparam int SUM_W      = 24;
    localparam int MEAN_W     = 24;
    localparam int COORD_W    = 12;
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_BIN    = 16;
    localparam int BIN_W      = 4;
    localparam int DIM_CFG_W  = 13;
    localparam int BIN_CFG_W  = 5;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CNT_W      = 9;
    localparam int FRAC_BITS  = 8;
    localparam int DIV_W      = 32;
    localparam int STEP_W     = 5;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_FACTOR   = 2'd2;

    typedef enum logic {
        DIV_IDLE,
        DIV_RUN
    } div_state_t;

    typedef struct packed {
        logic [DIV_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } div_req_t;

endpackage

/* sv/ibb_if.sv */
// Stream and configuration channel interfaces of the box binning core.
interface ibb_pixel_if;
    import ibb_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [PIXEL_BITS-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface ibb_block_if;
    import ibb_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [MEAN_W-1:0] block_mean;
    logic [COORD_W-1:0]       block_x;
    logic [COORD_W-1:0]       block_y;
    logic                     frame_done;

    modport source (output valid, output block_mean, output block_x, output block_y,
                    output frame_done, input ready);
    modport sink   (input valid, input block_mean, input block_x, input block_y,
                    input frame_done, output ready);
endinterface

interface ibb_cfg_if;
    import ibb_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/ibb_divider.sv */
// Restoring divider, one quotient bit per cycle, for the block mean.
module ibb_divider (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  ibb_pkg::div_req_t       req,
    output logic                    busy,
    output logic                    done,
    output logic [ibb_pkg::DIV_W-1:0] quotient
);
    import ibb_pkg::*;

    div_state_t          state_reg;
    div_state_t          state_next;
    logic [STEP_W-1:0]   step_reg;
    logic [DIV_W-1:0]    num_reg;
    logic [CNT_W-1:0]    den_reg;
    logic [CNT_W-1:0]    rem_reg;
    logic                done_reg;
    logic [CNT_W:0]      shifted;
    logic                ge;
    logic [CNT_W:0]      diff;
    logic                last_step;

    assign shifted   = {rem_reg, num_reg[DIV_W-1]};
    assign ge        = shifted >= {1'b0, den_reg};
    assign diff      = shifted - {1'b0, den_reg};
    assign last_step = step_reg == STEP_W'(DIV_W - 1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            DIV_IDLE:
            begin
                if (start)
                begin
                    state_next = DIV_RUN;
                end
            end
            DIV_RUN:
            begin
                if (last_step)
                begin
                    state_next = DIV_IDLE;
                end
            end
            default:
            begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == DIV_RUN) && last_step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == DIV_IDLE && start)
        begin
            num_reg  <= req.dividend;
            den_reg  <= req.divisor;
            rem_reg  <= '0;
            step_reg <= '0;
        end
        else if (state_reg == DIV_RUN)
        begin
            num_reg  <= {num_reg[DIV_W-2:0], ge};
            rem_reg  <= ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
            step_reg <= step_reg + STEP_W'(1);
        end
    end

    assign busy     = state_reg == DIV_RUN;
    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

/* sv/image_box_binning_core.sv */
// Top level of the streaming box binning core.
// A block result passes through the line store stage, the divider and the output register.
// Throughput: one pixel per cycle; a block-closing pixel waits while the divider
// (which works out one quotient bit at a time) or the output register still holds a block.
// Reset: geometry 1024 x 1024, bin 2, frame position at origin; line store
// contents undefined until written within a frame.
module image_box_binning_core (
    input  logic        clk,
    input  logic        rst_n,
    ibb_cfg_if.sink     cfg,
    ibb_pixel_if.sink   pixels,
    ibb_block_if.source blocks
);
    import ibb_pkg::*;

    logic [COORD_W-1:0]       w_m1_reg;
    logic [COORD_W-1:0]       h_m1_reg;
    logic [BIN_W-1:0]         b_m1_reg;
    logic [COORD_W-1:0]       x_reg;
    logic [COORD_W-1:0]       y_reg;
    logic [BIN_W-1:0]         cib_reg;
    logic [BIN_W-1:0]         rib_reg;
    logic [COORD_W-1:0]       bx_reg;
    logic [COORD_W-1:0]       by_reg;
    logic signed [SUM_W-1:0]  row_sum_reg;
    logic signed [SUM_W-1:0]  row_sum_next;

    logic                     s1_valid_reg;
    logic signed [SUM_W-1:0]  s1_sum_reg;
    logic                     s1_col_end_reg;
    logic                     s1_emit_reg;
    logic                     s1_use_mem_reg;
    logic [COORD_W-1:0]       s1_bx_reg;
    logic [COORD_W-1:0]       s1_by_reg;
    logic [CNT_W-1:0]         s1_count_reg;
    logic                     s1_img_end_reg;
    logic                     fwd_hit_reg;
    logic signed [SUM_W-1:0]  fwd_data_reg;

    logic signed [SUM_W-1:0]  col_mem [MAX_WIDTH];
    logic signed [SUM_W-1:0]  mem_rdata_reg;

    logic [COORD_W-1:0]       tag_bx_reg;
    logic [COORD_W-1:0]       tag_by_reg;
    logic                     tag_done_reg;
    logic                     tag_neg_reg;
    logic                     out_valid_reg;
    logic signed [MEAN_W-1:0] out_mean_reg;
    logic [COORD_W-1:0]       out_bx_reg;
    logic [COORD_W-1:0]       out_by_reg;
    logic                     out_done_reg;

    logic                     cfg_xfer;
    logic                     accept;
    logic                     img_row_end;
    logic                     last_row;
    logic                     img_end;
    logic                     col_end;
    logic                     blk_row_end;
    logic signed [SUM_W-1:0]  pixel_ext;
    logic [BIN_W:0]           cnt_a;
    logic [BIN_W:0]           cnt_b;
    logic [2*BIN_W+1:0]       cnt_prod;
    logic                     mem_re;
    logic                     mem_we;
    logic signed [SUM_W-1:0]  s1_total;
    logic                     occupied;
    logic                     s1_adv;
    logic                     div_start;
    logic [SUM_W-1:0]         total_mag;
    div_req_t                 div_req;
    logic                     div_busy;
    logic                     div_done;
    logic [DIV_W-1:0]         div_quo;
    logic [MEAN_W-1:0]        quo_mag;
    logic [COORD_W-1:0]       dim_m1;
    logic [BIN_W-1:0]         bin_m1;

    // Clamp configured dimensions to 1..MAX_WIDTH and bin to 1..MAX_BIN, store minus one
    always_comb
    begin
        if (cfg.data[DIM_CFG_W-1:0] == '0)
        begin
            dim_m1 = '0;
        end
        else if (cfg.data[DIM_CFG_W-1:0] > DIM_CFG_W'(MAX_WIDTH))
        begin
            dim_m1 = COORD_W'(MAX_WIDTH - 1);
        end
        else
        begin
            dim_m1 = COORD_W'(cfg.data[DIM_CFG_W-1:0] - DIM_CFG_W'(1));
        end
        if (cfg.data[BIN_CFG_W-1:0] == '0)
        begin
            bin_m1 = '0;
        end
        else if (cfg.data[BIN_CFG_W-1:0] > BIN_CFG_W'(MAX_BIN))
        begin
            bin_m1 = BIN_W'(MAX_BIN - 1);
        end
        else
        begin
            bin_m1 = BIN_W'(cfg.data[BIN_CFG_W-1:0] - BIN_CFG_W'(1));
        end
    end

    assign cfg.ready = 1'b1;
    assign cfg_xfer  = cfg.valid && cfg.ready;

    assign occupied      = div_busy || div_done || out_valid_reg;
    assign s1_adv        = s1_valid_reg && !(s1_emit_reg && occupied);
    assign pixels.ready  = !s1_valid_reg || s1_adv;
    assign accept        = pixels.valid && pixels.ready;

    assign img_row_end = x_reg == w_m1_reg;
    assign last_row    = y_reg == h_m1_reg;
    assign img_end     = img_row_end && last_row;
    assign col_end     = (cib_reg == b_m1_reg) || img_row_end;
    assign blk_row_end = (rib_reg == b_m1_reg) || last_row;

    assign pixel_ext    = SUM_W'(pixels.pixel);
    assign row_sum_next = (cib_reg == '0) ? pixel_ext : row_sum_reg + pixel_ext;
    assign cnt_a        = {1'b0, cib_reg} + (BIN_W+1)'(1);
    assign cnt_b        = {1'b0, rib_reg} + (BIN_W+1)'(1);
    assign cnt_prod     = cnt_a * cnt_b;

    assign mem_re   = accept && col_end && (rib_reg != '0);
    assign s1_total = s1_sum_reg + (s1_use_mem_reg ? (fwd_hit_reg ? fwd_data_reg : mem_rdata_reg)
                                                   : SUM_W'(0));
    assign mem_we   = s1_valid_reg && s1_col_end_reg && !s1_emit_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            col_mem[s1_bx_reg] <= s1_total;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= col_mem[bx_reg];
        end
    end

    // Geometry and frame position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_m1_reg    <= COORD_W'(1023);
            h_m1_reg    <= COORD_W'(1023);
            b_m1_reg    <= BIN_W'(1);
            x_reg       <= '0;
            y_reg       <= '0;
            cib_reg     <= '0;
            rib_reg     <= '0;
            bx_reg      <= '0;
            by_reg      <= '0;
            row_sum_reg <= '0;
        end
        else if (cfg_xfer)
        begin
            case (cfg.index)
                REG_IMAGE_WIDTH:  w_m1_reg <= dim_m1;
                REG_IMAGE_HEIGHT: h_m1_reg <= dim_m1;
                REG_BIN_FACTOR:   b_m1_reg <= bin_m1;
                default:          ;
            endcase
            if (cfg.index inside {REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_BIN_FACTOR})
            begin
                x_reg       <= '0;
                y_reg       <= '0;
                cib_reg     <= '0;
                rib_reg     <= '0;
                bx_reg      <= '0;
                by_reg      <= '0;
                row_sum_reg <= '0;
            end
        end
        else if (accept)
        begin
            row_sum_reg <= row_sum_next;
            if (img_row_end)
            begin
                x_reg   <= '0;
                cib_reg <= '0;
                bx_reg  <= '0;
                if (img_end)
                begin
                    y_reg   <= '0;
                    rib_reg <= '0;
                    by_reg  <= '0;
                end
                else
                begin
                    y_reg <= y_reg + COORD_W'(1);
                    if (rib_reg == b_m1_reg)
                    begin
                        rib_reg <= '0;
                        by_reg  <= by_reg + COORD_W'(1);
                    end
                    else
                    begin
                        rib_reg <= rib_reg + BIN_W'(1);
                    end
                end
            end
            else
            begin
                x_reg <= x_reg + COORD_W'(1);
                if (cib_reg == b_m1_reg)
                begin
                    cib_reg <= '0;
                    bx_reg  <= bx_reg + COORD_W'(1);
                end
                else
                begin
                    cib_reg <= cib_reg + BIN_W'(1);
                end
            end
        end
    end

    // Line store stage: hold a finished block until the divider and output register are free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sum_reg     <= row_sum_next;
            s1_col_end_reg <= col_end;
            s1_emit_reg    <= col_end && blk_row_end;
            s1_use_mem_reg <= rib_reg != '0;
            s1_bx_reg      <= bx_reg;
            s1_by_reg      <= by_reg;
            s1_count_reg   <= cnt_prod[CNT_W-1:0];
            s1_img_end_reg <= img_end;
            fwd_hit_reg    <= mem_we && (s1_bx_reg == bx_reg);
            fwd_data_reg   <= s1_total;
        end
    end

    assign div_start        = s1_adv && s1_emit_reg;
    assign total_mag        = s1_total[SUM_W-1] ? SUM_W'(-s1_total) : SUM_W'(s1_total);
    assign div_req.dividend = {total_mag, FRAC_BITS'(0)}
                              + DIV_W'(s1_count_reg[CNT_W-1:1]);
    assign div_req.divisor  = s1_count_reg;

    ibb_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .req      (div_req),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            tag_bx_reg   <= s1_bx_reg;
            tag_by_reg   <= s1_by_reg;
            tag_done_reg <= s1_img_end_reg;
            tag_neg_reg  <= s1_total[SUM_W-1];
        end
    end

    assign quo_mag = div_quo[MEAN_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (div_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (blocks.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_done)
        begin
            out_mean_reg <= tag_neg_reg ? MEAN_W'(-quo_mag) : MEAN_W'(quo_mag);
            out_bx_reg   <= tag_bx_reg;
            out_by_reg   <= tag_by_reg;
            out_done_reg <= tag_done_reg;
        end
    end

    assign blocks.valid      = out_valid_reg;
    assign blocks.block_mean = out_mean_reg;
    assign blocks.block_x    = out_bx_reg;
    assign blocks.block_y    = out_by_reg;
    assign blocks.frame_done = out_done_reg;

endmodule
